// ===== hw/rtl/pidtpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pidtpm_pkg
// Shared types, constants and helper functions of the two-axis PID tracker.
// ----------------------------------------------------------------------------
package pidtpm_pkg;

   // Number formats. State is signed Q32.16 in 48 bits; products and
   // quotients are carried in a 60-bit signed word.
   localparam int Q_W        = 48;
   localparam int Q_FRAC     = 16;
   localparam int PROD_W     = 60;
   localparam int TGT_W      = 12;
   localparam int OUT_W      = 32;

   // Configuration registers.
   localparam int KP_W       = 7;
   localparam int KI_W       = 5;
   localparam int KD_W       = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int GAIN_W     = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd2;

   // Constant-divisor division. The magnitude is taken in 20-bit chunks;
   // each chunk, with the running remainder on top, is a 30-bit partial
   // dividend whose quotient digit comes from a reciprocal product. The
   // reciprocal is ceil(2^s / d) with s = 30 + ceil(log2(d)), which is exact
   // for every partial dividend below 2^30.
   localparam int CHUNK_W    = 20;
   localparam int REM_W      = 10;
   localparam int PART_W     = REM_W + CHUNK_W;
   localparam int RECIP_W    = 31;
   localparam int RECIP_PW   = PART_W + RECIP_W;
   localparam int DIV_CHUNKS = PROD_W / CHUNK_W;
   localparam int DIV_CNT_W  = $clog2(DIV_CHUNKS);

   localparam int RECIP_SH_10   = 34;
   localparam int RECIP_SH_20   = 35;
   localparam int RECIP_SH_100  = 37;
   localparam int RECIP_SH_1000 = 40;

   localparam logic [RECIP_W-1:0] RECIP_10   = 31'd1717986919;
   localparam logic [RECIP_W-1:0] RECIP_20   = 31'd1717986919;
   localparam logic [RECIP_W-1:0] RECIP_100  = 31'd1374389535;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 31'd1099511628;

   // Microprogram.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   localparam logic signed [Q_W-1:0] GRAVITY_Q = 48'sd655360;
   localparam logic [GAIN_W-1:0]     DRAG_NUM  = 10'd9;

   typedef enum logic [1:0] {
      DIV_BY_10,
      DIV_BY_20,
      DIV_BY_100,
      DIV_BY_1000
   } div_sel_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_ERR,
      DP_INTEG,
      DP_MUL_P,
      DP_MUL_I,
      DP_MUL_D,
      DP_MUL_DRAG,
      DP_LD_FORCE,
      DP_LD_VEL,
      DP_DIV,
      DP_ACC_SET,
      DP_ACC_ADD,
      DP_CMD,
      DP_FORCE,
      DP_VEL,
      DP_POS,
      DP_OUT
   } dp_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type   op;
      div_sel_type sel;
      logic        axis;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   typedef struct packed {
      dp_op_type   op;
      div_sel_type sel;
   } uop_type;

   function automatic logic [REM_W-1:0] div_const(input div_sel_type sel);
      logic [REM_W-1:0] d;
      case (sel)
         DIV_BY_10:   d = 10'd10;
         DIV_BY_20:   d = 10'd20;
         DIV_BY_100:  d = 10'd100;
         DIV_BY_1000: d = 10'd1000;
         default:     d = 10'd10;
      endcase
      return d;
   endfunction

   function automatic logic [RECIP_W-1:0] div_recip(input div_sel_type sel);
      logic [RECIP_W-1:0] m;
      case (sel)
         DIV_BY_10:   m = RECIP_10;
         DIV_BY_20:   m = RECIP_20;
         DIV_BY_100:  m = RECIP_100;
         DIV_BY_1000: m = RECIP_1000;
         default:     m = RECIP_10;
      endcase
      return m;
   endfunction

   // Quotient digit out of the reciprocal product of one partial dividend.
   function automatic logic [CHUNK_W-1:0] div_digit(input div_sel_type sel,
                                                    input logic [RECIP_PW-1:0] p);
      logic [CHUNK_W-1:0] q;
      case (sel)
         DIV_BY_10:   q = p[RECIP_SH_10 +: CHUNK_W];
         DIV_BY_20:   q = p[RECIP_SH_20 +: CHUNK_W];
         DIV_BY_100:  q = p[RECIP_SH_100 +: CHUNK_W];
         DIV_BY_1000: q = p[RECIP_SH_1000 +: CHUNK_W];
         default:     q = p[RECIP_SH_10 +: CHUNK_W];
      endcase
      return q;
   endfunction

   // One axis worth of work. The same sequence runs for x and then y.
   function automatic uop_type prog_step(input logic [STEP_W-1:0] step);
      uop_type u;
      u.op  = DP_NOP;
      u.sel = DIV_BY_10;
      case (step)
         5'd0:  u.op = DP_ERR;
         5'd1:  u.op = DP_INTEG;
         5'd2:  u.op = DP_MUL_P;
         5'd3:  begin u.op = DP_DIV; u.sel = DIV_BY_100;  end
         5'd4:  u.op = DP_ACC_SET;
         5'd5:  u.op = DP_MUL_I;
         5'd6:  begin u.op = DP_DIV; u.sel = DIV_BY_1000; end
         5'd7:  u.op = DP_ACC_ADD;
         5'd8:  u.op = DP_MUL_D;
         5'd9:  begin u.op = DP_DIV; u.sel = DIV_BY_10;   end
         5'd10: u.op = DP_ACC_ADD;
         5'd11: u.op = DP_CMD;
         5'd12: u.op = DP_MUL_DRAG;
         5'd13: begin u.op = DP_DIV; u.sel = DIV_BY_10;   end
         5'd14: u.op = DP_FORCE;
         5'd15: u.op = DP_LD_FORCE;
         5'd16: begin u.op = DP_DIV; u.sel = DIV_BY_20;   end
         5'd17: u.op = DP_VEL;
         5'd18: u.op = DP_LD_VEL;
         5'd19: begin u.op = DP_DIV; u.sel = DIV_BY_20;   end
         5'd20: u.op = DP_POS;
         default: u.op = DP_NOP;
      endcase
      return u;
   endfunction

   function automatic logic signed [Q_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v[PROD_W-1:Q_W-1] == {(PROD_W-Q_W+1){v[PROD_W-1]}}) begin
         r = v[Q_W-1:0];
      end else if (v[PROD_W-1]) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [Q_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[Q_W-1:OUT_W-1] == {(Q_W-OUT_W+1){v[Q_W-1]}}) begin
         r = v[OUT_W-1:0];
      end else if (v[Q_W-1]) begin
         r = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/pid_tracked_point_mass_2d.sv =====
// ----------------------------------------------------------------------------
// pid_tracked_point_mass_2d
// Two-axis discrete PID controller steering a point mass with drag and
// gravity toward a target point, in saturating Q32.16 fixed point.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_target_x, req_target_y
//   rsp      out        rsp_valid/rsp_ready   rsp_position_x, rsp_position_y
//   csr      in         csr_wen (no wait)     csr_index, csr_wdata
//
// A new request is taken only once the previous beat has been handed to
// the output register. Most of the work is the shared constant divider:
// twelve divisions per beat (six per axis), each made of the start step,
// three 20-bit chunks, the sign fix-up and the handoff.
// Reset is synchronous and active high; it clears gains, integrals, stored
// errors, velocities and positions.
// A stalled response holds in its output register while the next request
// is accepted and worked on; only the final transfer waits for the slot.
//
// The work is split into a controller that sequences the steps and a
// datapath that holds the state, a single multiplier and the divider.
// Each axis runs the same sequence: error, integral, the three PID terms
// accumulated, the saturated command, drag, force, velocity, then position.
// The y axis subtracts a constant downward force. Every divide truncates
// toward zero; every stored value except products and their sum saturates to 48 bits.
// ----------------------------------------------------------------------------
module pid_tracked_point_mass_2d
   import pidtpm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [TGT_W-1:0]        req_target_x,
   input  logic [TGT_W-1:0]        req_target_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_position_x,
   output logic signed [OUT_W-1:0] rsp_position_y,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer: owns both handshakes and issues one datapath command per
   // cycle.
   pidtpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl_cmd  (dp_cmd),
      .dp_status (dp_status)
   );

   // Datapath: state, gains, multiplier, divider and output register.
   pidtpm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl_cmd       (dp_cmd),
      .dp_status      (dp_status),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .rsp_position_x (rsp_position_x),
      .rsp_position_y (rsp_position_y),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

`ifndef SYNTHESIS
   // Once a request is taken the block is busy for the whole computation.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous beat still in progress");

   // The output register is only loaded when its slot is free.
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == DP_OUT) |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten before being taken");

   // A new response beat always comes from the output transfer step.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.op == DP_OUT))
      else $error("response valid raised without an output transfer");
`endif

endmodule

// ===== hw/rtl/pidtpm_cdiv.sv =====
// ----------------------------------------------------------------------------
// pidtpm_cdiv
// Signed division by a small constant, truncating toward zero. The magnitude
// is worked in three 20-bit chunks, each in turn: a reciprocal product
// for the quotient digit, then the remainder carried into the next chunk.
// ----------------------------------------------------------------------------
module pidtpm_cdiv
   import pidtpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  div_sel_type              sel,
   input  logic signed [PROD_W-1:0] dividend,
   output logic                     done,
   output logic signed [PROD_W-1:0] quotient
);

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CHUNKS - 1);

   logic                      busy_ff, busy_in;
   logic                      rem_phase_ff;
   logic                      fix_ff, fix_in;
   logic                      done_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PROD_W-1:0]         num_ff, num_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [PROD_W-1:0]         quo_ff, quo_in;
   logic [PART_W-1:0]         part_ff, part_in;
   logic [CHUNK_W-1:0]        digit_ff, digit_in;
   logic                      neg_ff;
   div_sel_type               sel_ff;
   logic signed [PROD_W-1:0]  quot_ff;

   logic [PROD_W-1:0]         mag;
   logic [RECIP_PW-1:0]       recip_prod;
   logic [PART_W-1:0]         digit_times_d;
   logic [PART_W-1:0]         rem_full;

   assign mag = dividend[PROD_W-1] ? PROD_W'(~dividend + 1'b1) : PROD_W'(dividend);

   // The remainder stays below the divisor, so the partial dividend fits
   // 30 bits and its quotient digit fits one chunk.
   always_comb begin
      part_in       = {rem_ff, num_ff[PROD_W-1 -: CHUNK_W]};
      recip_prod    = RECIP_PW'(part_in) * RECIP_PW'(div_recip(sel_ff));
      digit_in      = div_digit(sel_ff, recip_prod);
      digit_times_d = PART_W'(digit_ff) * PART_W'(div_const(sel_ff));
      rem_full      = part_ff - digit_times_d;
      rem_in        = rem_full[REM_W-1:0];
      quo_in        = {quo_ff[PROD_W-CHUNK_W-1:0], digit_ff};
      num_in        = {num_ff[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      fix_in        = busy_ff && rem_phase_ff && (cnt_ff == CNT_LAST);
      busy_in       = !(rem_phase_ff && (cnt_ff == CNT_LAST));
      cnt_in        = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_phase_ff <= 1'b0;
         fix_ff       <= 1'b0;
         done_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         fix_ff  <= fix_in;
         done_ff <= fix_ff;
         if (start) begin
            busy_ff      <= 1'b1;
            rem_phase_ff <= 1'b0;
            cnt_ff       <= '0;
         end else if (busy_ff) begin
            busy_ff      <= busy_in;
            rem_phase_ff <= !rem_phase_ff;
            if (rem_phase_ff) begin
               cnt_ff <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= mag;
         rem_ff <= '0;
         quo_ff <= '0;
         neg_ff <= dividend[PROD_W-1];
         sel_ff <= sel;
      end else if (busy_ff) begin
         if (rem_phase_ff) begin
            num_ff <= num_in;
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end else begin
            part_ff  <= part_in;
            digit_ff <= digit_in;
         end
      end
      if (fix_ff) begin
         quot_ff <= neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== hw/rtl/pidtpm_dp.sv =====
// ----------------------------------------------------------------------------
// pidtpm_dp
// Datapath: per-axis state, gain registers, shared multiplier, shared
// constant divider and the saturating adders.
// ----------------------------------------------------------------------------
module pidtpm_dp
   import pidtpm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              ctrl_cmd,
   output dp_status_type           dp_status,
   input  logic [TGT_W-1:0]        req_target_x,
   input  logic [TGT_W-1:0]        req_target_y,
   output logic signed [OUT_W-1:0] rsp_position_x,
   output logic signed [OUT_W-1:0] rsp_position_y,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Gains.
   logic [KP_W-1:0] kp_ff;
   logic [KI_W-1:0] ki_ff;
   logic [KD_W-1:0] kd_ff;

   // Per-axis state, index 0 is x and index 1 is y.
   logic signed [Q_W-1:0] integ_ff [2];
   logic signed [Q_W-1:0] prev_ff  [2];
   logic signed [Q_W-1:0] vel_ff   [2];
   logic signed [Q_W-1:0] pos_ff   [2];

   // Working registers.
   logic [TGT_W-1:0]         tgt_x_ff, tgt_y_ff;
   logic signed [Q_W-1:0]    err_ff, err_in;
   logic signed [Q_W-1:0]    pid_cmd_ff, pid_cmd_in;
   logic signed [Q_W-1:0]    force_ff, force_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [OUT_W-1:0]  out_x_ff, out_y_ff;

   logic signed [Q_W-1:0]    integ_in, vel_in, pos_in;
   logic signed [Q_W-1:0]    integ_rd, prev_rd, vel_rd, pos_rd;
   logic [TGT_W-1:0]         tgt;
   logic signed [PROD_W-1:0] tgt_q;
   logic signed [Q_W-1:0]    bias;
   logic signed [GAIN_W:0]   mul_a;
   logic signed [Q_W:0]      mul_b;
   logic signed [PROD_W-1:0] mult_full;
   logic signed [PROD_W-1:0] quot;
   logic                     div_done;

   pidtpm_cdiv u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl_cmd.op == DP_DIV),
      .sel      (ctrl_cmd.sel),
      .dividend (prod_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign dp_status.div_done = div_done;

   assign mult_full = mul_a * mul_b;

   always_comb begin
      integ_rd = integ_ff[ctrl_cmd.axis];
      prev_rd  = prev_ff[ctrl_cmd.axis];
      vel_rd   = vel_ff[ctrl_cmd.axis];
      pos_rd   = pos_ff[ctrl_cmd.axis];
      tgt      = (ctrl_cmd.axis == AXIS_Y) ? tgt_y_ff : tgt_x_ff;
      tgt_q    = PROD_W'({tgt, {Q_FRAC{1'b0}}});
      bias     = (ctrl_cmd.axis == AXIS_Y) ? GRAVITY_Q : '0;

      case (ctrl_cmd.op)
         DP_MUL_P: begin
            mul_a = $signed((GAIN_W+1)'(kp_ff));
            mul_b = (Q_W+1)'(err_ff);
         end
         DP_MUL_I: begin
            mul_a = $signed((GAIN_W+1)'(ki_ff));
            mul_b = (Q_W+1)'(integ_rd);
         end
         DP_MUL_D: begin
            mul_a = $signed((GAIN_W+1)'(kd_ff));
            mul_b = (Q_W+1)'(err_ff) - (Q_W+1)'(prev_rd);
         end
         default: begin
            mul_a = $signed((GAIN_W+1)'(DRAG_NUM));
            mul_b = (Q_W+1)'(vel_rd);
         end
      endcase

      case (ctrl_cmd.op)
         DP_LD_FORCE: prod_in = PROD_W'(force_ff);
         DP_LD_VEL:   prod_in = PROD_W'(vel_rd);
         default:     prod_in = mult_full;
      endcase

      err_in     = sat48(tgt_q - PROD_W'(pos_rd));
      integ_in   = sat48(PROD_W'(integ_rd) + PROD_W'(err_ff));
      acc_in     = (ctrl_cmd.op == DP_ACC_SET) ? quot : acc_ff + quot;
      pid_cmd_in = sat48(acc_ff);
      force_in   = sat48(PROD_W'(pid_cmd_ff) - PROD_W'(bias) - quot);
      vel_in     = sat48(PROD_W'(vel_rd) + quot);
      pos_in     = sat48(PROD_W'(pos_rd) + quot);
   end

   // Architectural state and gains.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         for (int a = 0; a < 2; a++) begin
            integ_ff[a] <= '0;
            prev_ff[a]  <= '0;
            vel_ff[a]   <= '0;
            pos_ff[a]   <= '0;
         end
      end else begin
         case (ctrl_cmd.op)
            DP_INTEG: integ_ff[ctrl_cmd.axis] <= integ_in;
            DP_MUL_D: prev_ff[ctrl_cmd.axis]  <= err_ff;
            DP_VEL:   vel_ff[ctrl_cmd.axis]   <= vel_in;
            DP_POS:   pos_ff[ctrl_cmd.axis]   <= pos_in;
            default:  ;
         endcase
         if (csr_wen) begin
            case (csr_index)
               CSR_PROP_GAIN:  kp_ff <= csr_wdata[KP_W-1:0];
               CSR_INTEG_GAIN: begin
                  ki_ff       <= csr_wdata[KI_W-1:0];
                  integ_ff[0] <= '0;
                  integ_ff[1] <= '0;
               end
               CSR_DERIV_GAIN: kd_ff <= csr_wdata[KD_W-1:0];
               default:        ;
            endcase
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (ctrl_cmd.op)
         DP_LOAD: begin
            tgt_x_ff <= req_target_x;
            tgt_y_ff <= req_target_y;
         end
         DP_ERR:      err_ff     <= err_in;
         DP_MUL_P,
         DP_MUL_I,
         DP_MUL_D,
         DP_MUL_DRAG,
         DP_LD_FORCE,
         DP_LD_VEL:   prod_ff    <= prod_in;
         DP_ACC_SET,
         DP_ACC_ADD:  acc_ff     <= acc_in;
         DP_CMD:      pid_cmd_ff <= pid_cmd_in;
         DP_FORCE:    force_ff   <= force_in;
         DP_OUT: begin
            out_x_ff <= sat32(pos_ff[0]);
            out_y_ff <= sat32(pos_ff[1]);
         end
         default: ;
      endcase
   end

   assign rsp_position_x = out_x_ff;
   assign rsp_position_y = out_y_ff;

endmodule

// ===== hw/rtl/pidtpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidtpm_ctrl
// Controller: walks the per-axis microprogram for x then y, waits on the
// divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module pidtpm_ctrl
   import pidtpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    ctrl_cmd,
   input  dp_status_type dp_status
);

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   uop_type           uop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      axis_in       = axis_ff;
      rsp_valid_in  = rsp_valid_ff;
      advance       = 1'b0;
      uop           = prog_step(step_ff);
      ctrl_cmd.op   = DP_NOP;
      ctrl_cmd.sel  = DIV_BY_10;
      ctrl_cmd.axis = axis_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.op = DP_LOAD;
               state_in    = ST_RUN;
               step_in     = '0;
               axis_in     = AXIS_X;
            end
         end
         ST_RUN: begin
            ctrl_cmd.op  = uop.op;
            ctrl_cmd.sel = uop.sel;
            if (uop.op == DP_DIV) begin
               state_in = ST_WAIT;
            end else begin
               advance = 1'b1;
            end
         end
         ST_WAIT: begin
            if (dp_status.div_done) begin
               advance = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl_cmd.op  = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (advance) begin
         if (step_ff == LAST_STEP) begin
            step_in = '0;
            if (axis_ff == AXIS_Y) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = AXIS_Y;
               state_in = ST_RUN;
            end
         end else begin
            step_in  = step_ff + 1'b1;
            state_in = ST_RUN;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== verif/pidtpm_position_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidtpm_position_checker
// Watches the request, response and register ports of the two-axis PID
// tracker. It keeps its own copy of the gains and of the per-axis loop state,
// works out the position that each accepted target beat must produce, and
// compares each response beat with the oldest outstanding position.
// ----------------------------------------------------------------------------
module pidtpm_position_checker
   import pidtpm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [TGT_W-1:0]        req_target_x,
   input  logic [TGT_W-1:0]        req_target_y,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [OUT_W-1:0] rsp_position_x,
   input  logic signed [OUT_W-1:0] rsp_position_y,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      mismatch_count,
   output int                      outstanding_count
);

   localparam longint Q48_MAX     = (64'sd1 <<< (Q_W - 1)) - 64'sd1;
   localparam longint Q48_MIN     = -Q48_MAX - 64'sd1;
   localparam longint OUT_MAX     = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
   localparam longint OUT_MIN     = -OUT_MAX - 64'sd1;

   typedef struct packed {
      logic signed [Q_W-1:0] integ;
      logic signed [Q_W-1:0] last_err;
      logic signed [Q_W-1:0] vel;
      logic signed [Q_W-1:0] pos;
   } axis_state_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
   } position_type;

   logic [KP_W-1:0] kp_code;
   logic [KI_W-1:0] ki_code;
   logic [KD_W-1:0] kd_code;
   axis_state_type  axis_x;
   axis_state_type  axis_y;
   position_type    expected_positions[$];

   function automatic longint clamp_q48(input longint v);
      if (v > Q48_MAX) return Q48_MAX;
      if (v < Q48_MIN) return Q48_MIN;
      return v;
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [Q_W-1:0] v);
      longint w;
      w = longint'($signed(v));
      if (w > OUT_MAX) w = OUT_MAX;
      if (w < OUT_MIN) w = OUT_MIN;
      return w[OUT_W-1:0];
   endfunction

   // One control tick of one axis: PID command from the tracking error, then
   // an Euler step of the mass. Each term is truncated toward zero on its own.
   function automatic axis_state_type advance_axis(input axis_state_type s,
                                                   input logic [TGT_W-1:0] target,
                                                   input longint bias);
      axis_state_type n;
      longint err, acc, cmd, push, vel, pos;
      err  = clamp_q48((longint'(target) <<< Q_FRAC) - longint'($signed(s.pos)));
      acc  = clamp_q48(longint'($signed(s.integ)) + err);
      cmd  = clamp_q48(longint'(kp_code) * err / 100
                     + longint'(ki_code) * acc / 1000
                     + longint'(kd_code) * (err - longint'($signed(s.last_err))) / 10);
      push = clamp_q48(cmd - bias - 9 * longint'($signed(s.vel)) / 10);
      vel  = clamp_q48(longint'($signed(s.vel)) + push / 20);
      pos  = clamp_q48(longint'($signed(s.pos)) + vel / 20);
      n.integ    = acc[Q_W-1:0];
      n.last_err = err[Q_W-1:0];
      n.vel      = vel[Q_W-1:0];
      n.pos      = pos[Q_W-1:0];
      return n;
   endfunction

   task automatic log_failure(input string msg);
      mismatch_count++;
      $display("%s", msg);
   endtask

   // Inputs only move at the rising edge, so the middle of the cycle shows
   // exactly what the next rising edge will sample.
   always @(negedge clock) begin : track
      position_type want;
      if (reset) begin
         kp_code = '0;
         ki_code = '0;
         kd_code = '0;
         axis_x  = '0;
         axis_y  = '0;
         expected_positions.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_PROP_GAIN: begin
                  kp_code = csr_wdata[KP_W-1:0];
               end
               CSR_INTEG_GAIN: begin
                  ki_code      = csr_wdata[KI_W-1:0];
                  axis_x.integ = '0;
                  axis_y.integ = '0;
               end
               CSR_DERIV_GAIN: begin
                  kd_code = csr_wdata[KD_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            axis_x = advance_axis(axis_x, req_target_x, 64'sd0);
            axis_y = advance_axis(axis_y, req_target_y, longint'(GRAVITY_Q));
            want.x = clamp_out(axis_x.pos);
            want.y = clamp_out(axis_y.pos);
            expected_positions.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_positions.size() == 0) begin
               log_failure($sformatf("%0t: response beat with nothing outstanding (x %0d, y %0d)",
                                     $time, rsp_position_x, rsp_position_y));
            end else begin
               want = expected_positions.pop_front();
               if (rsp_position_x !== want.x) begin
                  log_failure($sformatf("%0t: position_x expected %0d, got %0d",
                                        $time, want.x, rsp_position_x));
               end
               if (rsp_position_y !== want.y) begin
                  log_failure($sformatf("%0t: position_y expected %0d, got %0d",
                                        $time, want.y, rsp_position_y));
               end
            end
         end
      end
      outstanding_count = expected_positions.size();
   end

endmodule

// ===== verif/tb_pid_tracked_point_mass_2d.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_tracked_point_mass_2d
// Drives target beats and gain writes into the two-axis PID tracker, idles
// and stalls both channels at random, and takes the verdict from the
// position checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_pid_tracked_point_mass_2d;
   import pidtpm_pkg::*;

   // Index 3 decodes to no register; writes there must leave all gains alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [TGT_W-1:0]     TGT_MAX      = '1;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int SETTLE_CYCLES   = 8;
   // Extra watch time at the end, in case the block emits a beat it was never
   // asked for.
   localparam int DRAIN_CYCLES    = 250;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [TGT_W-1:0]        req_target_x   = '0;
   logic [TGT_W-1:0]        req_target_y   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic signed [OUT_W-1:0] rsp_position_x;
   logic signed [OUT_W-1:0] rsp_position_y;
   logic                    csr_wen        = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;

   int mismatch_count;
   int outstanding_count;

   // When set, neither side inserts idle cycles, so beats go back to back.
   bit steady_flow = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pid_tracked_point_mass_2d u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position_x (rsp_position_x),
      .rsp_position_y (rsp_position_y),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   pidtpm_position_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_position_x    (rsp_position_x),
      .rsp_position_y    (rsp_position_y),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   // A correct run takes about 2.5 ms of simulated time; this leaves a wide
   // margin and catches a block that hangs or drops beats.
   initial begin : watchdog
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // One register write. The port has no wait, so the write lands at the
   // next rising edge.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // The raw words are written as given; the block keeps only the low bits
   // of each register.
   task automatic set_gains(input logic [CSR_DATA_W-1:0] prop,
                            input logic [CSR_DATA_W-1:0] integ,
                            input logic [CSR_DATA_W-1:0] deriv);
      write_csr(CSR_PROP_GAIN, prop);
      write_csr(CSR_INTEG_GAIN, integ);
      write_csr(CSR_DERIV_GAIN, deriv);
   endtask

   // Sends one target beat after a random idle gap. Valid is only lowered
   // when there is a gap, so back-to-back beats keep it high throughout.
   task automatic send_target(input logic [TGT_W-1:0] x, input logic [TGT_W-1:0] y);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_target_x <= x;
      req_target_y <= y;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // Holds off the sender until every outstanding position has come back,
   // so the block is idle before the gains change.
   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (outstanding_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Moves a coordinate by a small random step, clamped to the pixel range.
   function automatic logic [TGT_W-1:0] nudge_coord(input logic [TGT_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 128)) - 64;
      if (v < 0) v = 0;
      if (v > int'(TGT_MAX)) v = int'(TGT_MAX);
      return v[TGT_W-1:0];
   endfunction

   // Result side. For each beat a stall length is drawn; a nonzero stall
   // takes ready low and holds it there for that many cycles after the
   // position shows up, so the block has to keep its output steady.
   initial begin : response_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            do @(negedge clock); while (!rsp_valid);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [TGT_W-1:0] next_x;
      logic [TGT_W-1:0] next_y;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // With all gains at their reset value of zero, x just coasts and y
      // falls under gravity whatever the target is.
      send_target('0, '0);
      send_target(TGT_MAX, TGT_MAX);
      send_target(12'hAAA, 12'h555);

      // Top of the documented gain ranges, then a write to the unmapped
      // index that must change nothing.
      wait_idle();
      set_gains(10'd100, 10'd20, 10'd1000);
      write_csr(CSR_UNMAPPED, 10'h3FF);
      send_target(TGT_MAX, '0);
      send_target('0, TGT_MAX);
      send_target(TGT_MAX, TGT_MAX);
      send_target(12'd2048, 12'd2048);
      send_target(12'd2048, 12'd2048);
      send_target(12'd2048, 12'd2048);
      send_target('0, '0);
      send_target(12'h555, 12'hAAA);

      // Words with bits set above the proportional and integral registers'
      // widths: the block must keep only the low bits (37, 10 and 1023, the
      // last above the documented range).
      wait_idle();
      set_gains(10'h3A5, 10'h3EA, 10'h3FF);
      send_target(TGT_MAX, '0);
      send_target(TGT_MAX, '0);
      send_target('0, TGT_MAX);
      send_target(12'd100, 12'd3000);

      // Rewriting the integral gain with the same value still clears both
      // integrals.
      wait_idle();
      write_csr(CSR_INTEG_GAIN, 10'd10);
      send_target(12'd100, 12'd3000);
      send_target(12'd100, 12'd3000);
      send_target(TGT_MAX, TGT_MAX);
      send_target('0, '0);

      // Random phases. Each one starts from an idle block with a new gain
      // setting; the targets mostly hold or drift so the loop settles and
      // tracks, with jumps and corners mixed in.
      next_x = '0;
      next_y = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         steady_flow = (phase % 3 == 2);
         case (phase)
            1: begin
               set_gains('0, '0, '0);
            end
            2: begin
               set_gains(10'd100, 10'd20, 10'd1000);
            end
            5: begin
               set_gains('1, '1, '1);
            end
            default: begin
               set_gains(CSR_DATA_W'($urandom_range(0, 1023)),
                         CSR_DATA_W'($urandom_range(0, 1023)),
                         CSR_DATA_W'($urandom_range(0, 1023)));
            end
         endcase
         if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom_range(0, 1023)));
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
               end
               4, 5, 6: begin
                  next_x = nudge_coord(next_x);
                  next_y = nudge_coord(next_y);
               end
               7, 8: begin
                  next_x = TGT_W'($urandom_range(0, int'(TGT_MAX)));
                  next_y = TGT_W'($urandom_range(0, int'(TGT_MAX)));
               end
               default: begin
                  next_x = ($urandom_range(0, 1) == 1) ? TGT_MAX : '0;
                  next_y = ($urandom_range(0, 1) == 1) ? TGT_MAX : '0;
               end
            endcase
            send_target(next_x, next_y);
         end
      end

      // Let every outstanding position come back, then watch a while longer
      // for any beat that should not be there.
      req_valid <= 1'b0;
      wait (outstanding_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
